// File: design/ssp_pkg.sv
// shared types, constants and sine table function for the scratch sample player
package ssp_pkg;

  localparam int CFG_W = 20;
  localparam logic [23:0] VEL_FLOOR = 24'd6;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [34:0] SCALE_DIV = 35'd65025;
  localparam logic [63:0] RECIP_FULL = (64'd1 << 48) / 64'd65025;
  localparam logic [33:0] RECIP = RECIP_FULL[33:0];

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_REGION_START = 3'd1,
    REG_REGION_END   = 3'd2,
    REG_SWING_DEPTH  = 3'd3,
    REG_GESTURE_STEP = 3'd4,
    REG_WAVE_SHAPE   = 3'd5,
    REG_FADER_CUT    = 3'd6,
    REG_VOLUME       = 3'd7
  } reg_t;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_SINE_ALT = 2'd3
  } wave_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_FAC,
    ST_VEL,
    ST_A0,
    ST_A1,
    ST_SC,
    ST_RQ,
    ST_RC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        idx;
    logic signed [15:0] sample;
    logic [19:0]        rate;
  } cmd_t;

  typedef struct packed {
    logic [16:0] sample_count;
    logic [15:0] region_start;
    logic [15:0] region_end;
    logic [9:0]  swing_depth;
    logic [19:0] gesture_step;
    logic [1:0]  wave_shape;
    logic [7:0]  fader_cut;
    logic [7:0]  volume;
  } cfg_t;

  // quarter-wave taylor series, p is the phase as a fraction of 2^32
  function automatic logic signed [15:0] sine_val(input logic [63:0] p);
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic signed [15:0] v;
    begin
      quad = (p >> 30) & 64'd3;
      r = p & 64'h3FFF_FFFF;
      q = quad[0] ? (64'h4000_0000 - r) : r;
      x = (q * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + term;
      sum = (sum + 64'd16384) >> 15;
      if (sum > 64'd32767) begin
        sum = 64'd32767;
      end
      v = $signed(sum[15:0]);
      return (quad >= 64'd2) ? -v : v;
    end
  endfunction

endpackage

// File: design/ssp_in_if.sv
// request channel carrying one operation
interface ssp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        load_index;
  logic signed [15:0] load_sample;
  logic [19:0]        note_rate;

  modport source (output valid, op, load_index, load_sample, note_rate, input ready);
  modport sink (input valid, op, load_index, load_sample, note_rate, output ready);
endinterface

// File: design/ssp_out_if.sv
// result channel carrying one audio sample
interface ssp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink (input valid, audio_out, output ready);
endinterface

// File: design/ssp_front.sv
// request intake, decode and two-entry command queue
module ssp_front #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  ssp_in_if.sink         in_ch,
  output logic           q_valid,
  output ssp_pkg::cmd_t  q_head,
  input  logic           q_pop
);

  localparam logic [31:0] DEPTH_W = 32'(MEM_DEPTH);

  ssp_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          keep;
  logic          push;
  logic          pop;
  ssp_pkg::cmd_t cmd;

  // loads beyond the store are dropped here
  always_comb begin
    cmd.op = ssp_pkg::op_t'(in_ch.op);
    cmd.idx = in_ch.load_index;
    cmd.sample = in_ch.load_sample;
    cmd.rate = in_ch.note_rate;
    keep = !((cmd.op == ssp_pkg::OP_LOAD) && ({16'd0, in_ch.load_index} >= DEPTH_W));
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && keep;
  assign pop = q_pop && (cnt_r != 2'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/ssp_back.sv
// sequenced datapath: sample store, gesture oscillator, shared multiplier, output register
module ssp_back #(
  parameter int MEM_DEPTH        = 65536,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ssp_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  ssp_pkg::cmd_t q_head,
  output logic          q_pop,
  ssp_out_if.source     out_ch
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int TW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(MEM_DEPTH);

  logic signed [15:0] mem [MEM_DEPTH];
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam logic [63:0] PH = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    assign sine_rom[k] = ssp_pkg::sine_val(PH);
  end

  ssp_pkg::state_t state_r, state_nxt;
  logic               playing_r;
  logic [31:0]        pos_r;
  logic [19:0]        rate_r;
  logic [23:0]        phase_r;
  logic signed [15:0] mod_r;
  logic [7:0]         gate_r;
  logic [15:0]        gv_r;
  logic signed [26:0] factor_r;
  logic signed [24:0] vel_r;
  logic signed [15:0] s0_r;
  logic signed [15:0] s1_r;
  logic [15:0]        frac_r;
  logic signed [33:0] acc_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic [16:0]        q0_r;
  logic signed [15:0] res_r;
  logic               upd_r;
  logic               out_valid_r;
  logic signed [15:0] out_audio_r;
  logic signed [15:0] rd_q_r;

  logic [16:0] n;
  logic [16:0] n_m1;
  logic [16:0] lo;
  logic [16:0] hi;
  logic [16:0] ra;
  logic [16:0] rb;
  logic [16:0] ci0;
  logic [16:0] ci1;
  logic [16:0] rsel;
  logic [31:0] ra32;
  logic [31:0] wa32;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          mem_we;
  logic          slot_free;

  logic [23:0]        tdist;
  logic signed [17:0] tri_w;
  logic signed [16:0] saw_w;
  logic [36:0]        sprod;
  logic [TW-1:0]      sidx;
  logic signed [15:0] mod_w;
  logic [7:0]         gate_w;

  logic signed [34:0] ma;
  logic signed [34:0] mb;
  logic signed [69:0] mp;

  logic signed [46:0] vprod;
  logic [46:0]        vabs;
  logic [23:0]        vmag;
  logic               still;
  logic signed [49:0] xprod;
  logic [49:0]        xabs;
  logic [32:0]        rem;
  logic [17:0]        qv;
  logic signed [15:0] res_w;

  logic signed [34:0] pos_sum;
  logic signed [34:0] pos_wr;
  logic signed [34:0] hi_f;
  logic signed [34:0] lo_f;
  logic [31:0]        pos_new;

  // effective store length and loop region
  always_comb begin
    n = ({15'd0, cfg.sample_count} > DEPTH_W) ? DEPTH_W[16:0] : cfg.sample_count;
    n_m1 = n - 17'd1;
    ra = {1'b0, cfg.region_start};
    rb = {1'b0, cfg.region_end};
    if (rb >= n) begin
      rb = n_m1;
    end
    if (rb <= ra) begin
      ra = 17'd0;
      rb = n_m1;
    end
    lo = ra;
    hi = rb;
  end

  // interpolation read addresses
  always_comb begin
    ci0 = ({1'b0, pos_r[31:16]} >= n) ? n_m1 : {1'b0, pos_r[31:16]};
    ci1 = ({1'b0, pos_r[31:16]} + 17'd1 >= n) ? n_m1 : ({1'b0, pos_r[31:16]} + 17'd1);
    rsel = (state_r == ssp_pkg::ST_FAC) ? ci1 : ci0;
    ra32 = {15'd0, rsel};
    wa32 = {16'd0, q_head.idx};
    rd_addr = ra32[AW-1:0];
    wr_addr = wa32[AW-1:0];
  end

  // gesture oscillator
  always_comb begin
    tdist = (phase_r >= 24'h800000) ? (phase_r - 24'h800000) : (24'h800000 - phase_r);
    tri_w = 18'sd32768 - $signed({1'b0, tdist[23:7]});
    saw_w = $signed({1'b0, phase_r[23:8]}) - 17'sd32768;
    sprod = {13'd0, phase_r} * 37'(SINE_TABLE_DEPTH);
    sidx = sprod[24 +: TW];
    case (ssp_pkg::wave_t'(cfg.wave_shape))
      ssp_pkg::WAVE_TRIANGLE: mod_w = (tri_w > 18'sd32767) ? 16'sd32767 : tri_w[15:0];
      ssp_pkg::WAVE_SAW:      mod_w = saw_w[15:0];
      default:                mod_w = sine_rom[sidx];
    endcase
    gate_w = ((cfg.fader_cut != 8'd0) && (mod_w > 16'sd0)) ? (8'd255 - cfg.fader_cut) : 8'd255;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ssp_pkg::ST_MOD: begin
        ma = $signed({27'd0, gate_w});
        mb = $signed({27'd0, cfg.volume});
      end
      ssp_pkg::ST_FAC: begin
        ma = $signed({25'd0, cfg.swing_depth});
        mb = {{19{mod_r[15]}}, mod_r};
      end
      ssp_pkg::ST_VEL: begin
        ma = $signed({15'd0, rate_r});
        mb = {{8{factor_r[26]}}, factor_r};
      end
      ssp_pkg::ST_A0: begin
        ma = {{19{s0_r[15]}}, s0_r};
        mb = $signed(35'd65536 - {19'd0, frac_r});
      end
      ssp_pkg::ST_A1: begin
        ma = {{19{s1_r[15]}}, s1_r};
        mb = $signed({19'd0, frac_r});
      end
      ssp_pkg::ST_SC: begin
        ma = {{1{acc_r[33]}}, acc_r};
        mb = $signed({19'd0, gv_r});
      end
      ssp_pkg::ST_RQ: begin
        ma = $signed({3'd0, mag_r});
        mb = $signed({1'b0, ssp_pkg::RECIP});
      end
      ssp_pkg::ST_RC: begin
        ma = $signed({18'd0, q0_r});
        mb = $signed(ssp_pkg::SCALE_DIV);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mp = ma * mb;
  end

  // velocity, scaling and rounding helpers
  always_comb begin
    vprod = mp[46:0];
    vabs = vprod[46] ? (47'd0 - vprod) : vprod;
    vmag = vabs[46:23];
    still = (vmag <= ssp_pkg::VEL_FLOOR) || (gate_r == 8'd0);
    xprod = mp[49:0];
    xabs = xprod[49] ? (50'd0 - xprod) : xprod;
    rem = {1'b0, mag_r} - mp[32:0];
    qv = (rem >= ssp_pkg::SCALE_DIV[32:0]) ? ({1'b0, q0_r} + 18'd1) : {1'b0, q0_r};
    if (neg_r) begin
      res_w = (qv > 18'd32768) ? -16'sd32768 : (16'sd0 - $signed(qv[15:0]));
    end else begin
      res_w = (qv > 18'd32767) ? 16'sd32767 : $signed(qv[15:0]);
    end
  end

  // needle move and region wrap
  always_comb begin
    pos_sum = $signed({3'd0, pos_r}) + {{10{vel_r[24]}}, vel_r};
    hi_f = $signed({2'd0, hi, 16'd0});
    lo_f = $signed({2'd0, lo, 16'd0});
    pos_wr = pos_sum;
    if (hi > lo) begin
      if (pos_sum >= hi_f) begin
        pos_wr = pos_sum - (hi_f - lo_f);
      end else if (pos_sum < lo_f) begin
        pos_wr = pos_sum + (hi_f - lo_f);
      end
    end
    if (pos_wr < 35'sd0) begin
      pos_new = 32'd0;
    end else if (pos_wr > $signed(35'h0FFFFFFFF)) begin
      pos_new = 32'hFFFF_FFFF;
    end else begin
      pos_new = pos_wr[31:0];
    end
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    mem_we = 1'b0;
    case (state_r)
      ssp_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            ssp_pkg::OP_LOAD: mem_we = 1'b1;
            ssp_pkg::OP_TICK: begin
              state_nxt = (playing_r && (n != 17'd0)) ? ssp_pkg::ST_MOD : ssp_pkg::ST_EMIT;
            end
            default: state_nxt = ssp_pkg::ST_IDLE;
          endcase
        end
      end
      ssp_pkg::ST_MOD: state_nxt = ssp_pkg::ST_FAC;
      ssp_pkg::ST_FAC: state_nxt = ssp_pkg::ST_VEL;
      ssp_pkg::ST_VEL: state_nxt = still ? ssp_pkg::ST_EMIT : ssp_pkg::ST_A0;
      ssp_pkg::ST_A0:  state_nxt = ssp_pkg::ST_A1;
      ssp_pkg::ST_A1:  state_nxt = ssp_pkg::ST_SC;
      ssp_pkg::ST_SC:  state_nxt = ssp_pkg::ST_RQ;
      ssp_pkg::ST_RQ:  state_nxt = ssp_pkg::ST_RC;
      ssp_pkg::ST_RC:  state_nxt = ssp_pkg::ST_EMIT;
      ssp_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ssp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssp_pkg::ST_IDLE;
    endcase
  end

  // sample store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= q_head.sample;
    end
    rd_q_r <= mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ssp_pkg::ST_IDLE: begin
        res_r <= 16'sd0;
        upd_r <= 1'b0;
      end
      ssp_pkg::ST_MOD: begin
        mod_r <= mod_w;
        gate_r <= gate_w;
        gv_r <= mp[15:0];
        frac_r <= pos_r[15:0];
      end
      ssp_pkg::ST_FAC: begin
        factor_r <= 27'sd8388608 + mp[26:0];
        s0_r <= rd_q_r;
      end
      ssp_pkg::ST_VEL: begin
        vel_r <= vprod[46] ? (25'sd0 - $signed({1'b0, vmag})) : $signed({1'b0, vmag});
        s1_r <= rd_q_r;
        res_r <= 16'sd0;
        upd_r <= 1'b1;
      end
      ssp_pkg::ST_A0: acc_r <= mp[33:0];
      ssp_pkg::ST_A1: acc_r <= acc_r + mp[33:0];
      ssp_pkg::ST_SC: begin
        neg_r <= xprod[49];
        mag_r <= xabs[47:16];
      end
      ssp_pkg::ST_RQ: q0_r <= mp[64:48];
      ssp_pkg::ST_RC: res_r <= res_w;
      default: res_r <= res_r;
    endcase
  end

  // control state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssp_pkg::ST_IDLE;
      playing_r <= 1'b0;
      pos_r <= 32'd0;
      rate_r <= 20'd0;
      phase_r <= 24'd0;
      out_valid_r <= 1'b0;
      out_audio_r <= 16'sd0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ssp_pkg::ST_IDLE) && q_valid) begin
        if ((q_head.op == ssp_pkg::OP_NOTE_ON) && (n != 17'd0)) begin
          rate_r <= q_head.rate;
          pos_r <= {lo[15:0], 16'd0};
          phase_r <= 24'd0;
          playing_r <= 1'b1;
        end else if (q_head.op == ssp_pkg::OP_NOTE_OFF) begin
          playing_r <= 1'b0;
        end
      end
      if ((state_r == ssp_pkg::ST_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
        out_audio_r <= res_r;
        if (upd_r) begin
          pos_r <= pos_new;
          phase_r <= phase_r + {4'd0, cfg.gesture_step};
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.audio_out = out_audio_r;

endmodule

// File: design/scratch_sample_player.sv
// scratch sample player top level: register file, intake and datapath
//
// requests enter on in_ch (valid/ready): load a sample word, note on, note off
// or tick. only a tick gives a result, one signed 16-bit sample on out_ch.
// registers are written through cfg_we/cfg_index/cfg_data; writing them only
// while idle is the user's duty, unchecked by the block. a request sits in a
// two-entry queue, then the sequencer takes it: load, note on and note off
// stay in idle. a playing tick runs through the sequencer states around one
// shared multiplier (oscillator, velocity, two interpolation products, gain,
// reciprocal divide, correction, emit); a tick with a still platter goes
// from velocity to emit, a stopped one from idle. no request is taken before
// the emit. the result waits in an output register; while the receiver
// stalls the queue takes requests until it is full, then in_ch.ready drops.
// reset stops playback, clears needle, rate and gesture phase and loads
// register defaults; the sample store is not cleared and needs no pass.
module scratch_sample_player #(
  parameter int MEM_DEPTH        = 65536,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ssp_in_if.sink                     in_ch,
  ssp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [ssp_pkg::CFG_W-1:0]  cfg_data
);

  ssp_pkg::cfg_t cfg_r;
  ssp_pkg::cmd_t q_head;
  logic          q_valid;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= 17'd0;
      cfg_r.region_start <= 16'd0;
      cfg_r.region_end <= 16'hFFFF;
      cfg_r.swing_depth <= 10'd0;
      cfg_r.gesture_step <= 20'd0;
      cfg_r.wave_shape <= 2'd0;
      cfg_r.fader_cut <= 8'd0;
      cfg_r.volume <= 8'd200;
    end else if (cfg_we) begin
      case (ssp_pkg::reg_t'(cfg_index))
        ssp_pkg::REG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_data[16:0];
        ssp_pkg::REG_REGION_START: cfg_r.region_start <= cfg_data[15:0];
        ssp_pkg::REG_REGION_END:   cfg_r.region_end <= cfg_data[15:0];
        ssp_pkg::REG_SWING_DEPTH:  cfg_r.swing_depth <= cfg_data[9:0];
        ssp_pkg::REG_GESTURE_STEP: cfg_r.gesture_step <= cfg_data[19:0];
        ssp_pkg::REG_WAVE_SHAPE:   cfg_r.wave_shape <= cfg_data[1:0];
        ssp_pkg::REG_FADER_CUT:    cfg_r.fader_cut <= cfg_data[7:0];
        ssp_pkg::REG_VOLUME:       cfg_r.volume <= cfg_data[7:0];
        default:                   cfg_r <= cfg_r;
      endcase
    end
  end

  ssp_front #(
    .MEM_DEPTH(MEM_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  ssp_back #(
    .MEM_DEPTH       (MEM_DEPTH),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_valid(q_valid),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
